FILE: src/mce_pkg.sv
// Shared types, codes, defaults and helper functions of the checksum engine.
package mce_pkg;

	localparam int CHUNK_WORDS_DEF = 360;
	localparam int MID_DEPTH_DEF   = 4;
	localparam int OUT_DEPTH_DEF   = 4;

	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY_RST  = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_LIMIT_RST = 32'd256;
	localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

	// Configuration register indexes.
	localparam logic [1:0] REG_ALGO_MODE = 2'd0;
	localparam logic [1:0] REG_CRC_LIMIT = 2'd1;
	localparam logic [1:0] REG_CRC_POLY  = 2'd2;

	// Algorithm select codes; the unused code behaves as auto.
	localparam logic [1:0] MODE_AUTO     = 2'd0;
	localparam logic [1:0] MODE_CRC      = 2'd1;
	localparam logic [1:0] MODE_FLETCHER = 2'd2;

	// Classified byte request, front to back.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       pair;    // completes a 16-bit word with the held byte
		logic       use_fl;  // Fletcher chosen (meaningful on last only)
	} mce_req_t;

	// One finished checksum.
	typedef struct packed {
		logic [31:0] checksum;
		logic        algo_used;
	} mce_res_t;

	function automatic logic [31:0] fold16(input logic [31:0] x);
		return {16'd0, x[15:0]} + {16'd0, x[31:16]};
	endfunction

	// Eight right-shift CRC bit steps over one byte.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
			input logic [31:0] poly);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = poly ^ {1'b0, c[31:1]};
			end else begin
				c = {1'b0, c[31:1]};
			end
		end
		return c;
	endfunction

endpackage

FILE: src/mce_fifo.sv
// Small register queue used between front and back and on the result side.
module mce_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mce_pkg::MID_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	import mce_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

FILE: src/mce_front.sv
// Front part: tracks byte pairing and length, tags each byte request.
module mce_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              last,
	input  logic [1:0]        algo_mode,
	input  logic [31:0]       crc_limit,
	output mce_pkg::mce_req_t req
);
	import mce_pkg::*;

	logic [31:0] count_q;
	logic        held_q;
	logic [31:0] count_next;
	logic        use_fl;

	assign count_next = (count_q == COUNT_MAX) ? count_q : count_q + 32'd1;

	always_comb begin
		case (algo_mode)
			MODE_CRC:      use_fl = 1'b0;
			MODE_FLETCHER: use_fl = 1'b1;
			default:       use_fl = !(count_next < crc_limit);
		endcase
	end

	assign req = '{data: data_byte, last: last, pair: held_q, use_fl: use_fl};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			held_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
				held_q  <= 1'b0;
			end else begin
				count_q <= count_next;
				held_q  <= !held_q;
			end
		end
	end

endmodule

FILE: src/mce_back.sv
// Back part: CRC and Fletcher accumulation, then a two-stage finishing pipeline.
module mce_back #(
	parameter int CHUNK_WORDS = mce_pkg::CHUNK_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  mce_pkg::mce_req_t req,
	output logic              req_take,
	input  logic              out_ready,
	input  logic [31:0]       crc_poly,
	output logic              res_valid,
	output mce_pkg::mce_res_t res
);
	import mce_pkg::*;

	localparam int WIC_W = $clog2(CHUNK_WORDS + 1);

	// Running message state.
	logic [31:0]      crc_q, lo_q, hi_q;
	logic [WIC_W-1:0] wic_q;
	logic [7:0]       held_byte_q;

	logic [31:0]      crc_n, lo_n, hi_n, lo_add, hi_add;
	logic [WIC_W-1:0] wic_n;
	logic [7:0]       held_byte_n;
	logic             chunk_end;

	// Finishing pipeline.
	logic             valid_s1, valid_s2;
	logic [31:0]      lo_s1, hi_s1, crc_s1, lo_s2, hi_s2, crc_s2;
	logic             wnz_s1, odd_s1, fl_s1, odd_s2, fl_s2;
	logic [7:0]       held_s1;
	logic [31:0]      lo_a, hi_a, lo_b, hi_b, lo_c, hi_c, lo_d, hi_d;

	assign req_take = req_valid && out_ready;

	assign crc_n     = crc_byte(crc_q, req.data, crc_poly);
	assign lo_add    = lo_q + {16'd0, held_byte_q, req.data};
	assign hi_add    = hi_q + lo_add;
	assign chunk_end = (wic_q == WIC_W'(CHUNK_WORDS - 1));

	always_comb begin
		lo_n        = lo_q;
		hi_n        = hi_q;
		wic_n       = wic_q;
		held_byte_n = held_byte_q;
		if (req.pair) begin
			lo_n  = chunk_end ? fold16(lo_add) : lo_add;
			hi_n  = chunk_end ? fold16(hi_add) : hi_add;
			wic_n = chunk_end ? '0 : wic_q + 1'b1;
		end else begin
			held_byte_n = req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_INIT;
			lo_q        <= '0;
			hi_q        <= '0;
			wic_q       <= '0;
			held_byte_q <= '0;
		end else if (req_take) begin
			if (req.last) begin
				crc_q       <= CRC_INIT;
				lo_q        <= '0;
				hi_q        <= '0;
				wic_q       <= '0;
				held_byte_q <= '0;
			end else begin
				crc_q       <= crc_n;
				lo_q        <= lo_n;
				hi_q        <= hi_n;
				wic_q       <= wic_n;
				held_byte_q <= held_byte_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (out_ready) begin
			valid_s1 <= req_take && req.last;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1 captures the state after the last byte.
	always_ff @(posedge clk) begin
		if (out_ready) begin
			lo_s1   <= lo_n;
			hi_s1   <= hi_n;
			wnz_s1  <= (wic_n != '0);
			odd_s1  <= !req.pair;
			held_s1 <= req.data;
			crc_s1  <= crc_n ^ CRC_INIT;
			fl_s1   <= req.use_fl;
		end
	end

	// Fold a partial chunk, then add an odd trailing byte in the high half.
	assign lo_a = wnz_s1 ? fold16(lo_s1) : lo_s1;
	assign hi_a = wnz_s1 ? fold16(hi_s1) : hi_s1;
	assign lo_b = lo_a + (odd_s1 ? {16'd0, held_s1, 8'd0} : 32'd0);
	assign hi_b = hi_a + (odd_s1 ? lo_b : 32'd0);

	always_ff @(posedge clk) begin
		if (out_ready) begin
			lo_s2  <= lo_b;
			hi_s2  <= hi_b;
			odd_s2 <= odd_s1;
			crc_s2 <= crc_s1;
			fl_s2  <= fl_s1;
		end
	end

	assign lo_c = odd_s2 ? fold16(lo_s2) : lo_s2;
	assign hi_c = odd_s2 ? fold16(hi_s2) : hi_s2;
	assign lo_d = fold16(lo_c);
	assign hi_d = fold16(hi_c);

	assign res_valid     = valid_s2;
	assign res.checksum  = fl_s2 ? {hi_d[15:0], lo_d[15:0]} : crc_s2;
	assign res.algo_used = fl_s2;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ready |=> $stable(valid_s1) && $stable(valid_s2))
		else $error("finishing pipeline moved while stalled");

	a_last_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && req.last |=> valid_s1)
		else $error("last byte did not enter finishing pipeline");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && req.last |=> crc_q == CRC_INIT && lo_q == '0 && hi_q == '0
			&& wic_q == '0)
		else $error("message state not cleared after last byte");

endmodule

FILE: src/metadata_checksum_engine.sv
// Top level of the 32-bit CRC / Fletcher-32 byte-stream checksum engine.
// Throughput: one byte request per cycle while results are taken.
// Path: a result reaches the result ports after its last byte is accepted and
//   passes the request queue, then two finishing stages, then the result queue.
// Stalls: a full result queue stalls the finishing stages and the back part.
// Reset: arst_n clears message state, both queues and registers to defaults.
module metadata_checksum_engine #(
	parameter int CHUNK_WORDS = mce_pkg::CHUNK_WORDS_DEF,
	parameter int MID_DEPTH   = mce_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH   = mce_pkg::OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte requests
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last,
	// results
	output logic        empty,
	input  logic        pop,
	output logic [31:0] checksum,
	output logic        algo_used,
	// configuration writes
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import mce_pkg::*;

	localparam int REQ_W = $bits(mce_req_t);
	localparam int RES_W = $bits(mce_res_t);

	logic [1:0]  algo_mode_q;
	logic [31:0] crc_limit_q, crc_poly_q;

	logic        accept;
	mce_req_t    front_req, back_req;
	logic        mid_empty, req_take;
	logic        out_full, res_valid;
	mce_res_t    back_res, out_res;

	// Configuration registers; write them only while no request is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			algo_mode_q <= MODE_AUTO;
			crc_limit_q <= CRC_LIMIT_RST;
			crc_poly_q  <= CRC_POLY_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ALGO_MODE: algo_mode_q <= cfg_data[1:0];
				REG_CRC_LIMIT: crc_limit_q <= cfg_data;
				REG_CRC_POLY:  crc_poly_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Take a byte whenever the request queue has room.
	assign accept = push && !full;

	// Front: pair bytes into words, count length, pick the algorithm on last.
	mce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.data_byte(data_byte),
		.last     (last),
		.algo_mode(algo_mode_q),
		.crc_limit(crc_limit_q),
		.req      (front_req)
	);

	// Request queue decouples the front from back-side stalls.
	mce_fifo #(
		.WIDTH(REQ_W),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (accept),
		.wdata (front_req),
		.rd    (req_take),
		.rdata (back_req),
		.full  (full),
		.empty (mid_empty)
	);

	// Back: advance both checksums per byte and finish them on last.
	mce_back #(
		.CHUNK_WORDS(CHUNK_WORDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(!mid_empty),
		.req      (back_req),
		.req_take (req_take),
		.out_ready(!out_full),
		.crc_poly (crc_poly_q),
		.res_valid(res_valid),
		.res      (back_res)
	);

	// Result queue holds finished checksums until popped.
	mce_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_valid && !out_full),
		.wdata (back_res),
		.rd    (pop),
		.rdata (out_res),
		.full  (out_full),
		.empty (empty)
	);

	assign checksum  = out_res.checksum;
	assign algo_used = out_res.algo_used;

endmodule
